@@ rtl/float_to_decimal_ascii_assert.svh @@
// assertion macros for the float to decimal text block
// no dependencies; included inside the f2da_back module body, which checks its own logic
`ifndef FLOAT_TO_DECIMAL_ASCII_ASSERT_SVH
`define FLOAT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define F2DA_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("f2da check failed");

// next-cycle implication
`define F2DA_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("f2da check failed");

`endif

@@ rtl/f2da_pkg.sv @@
// shared types and constants for the float to decimal text block
// no dependencies
package f2da_pkg;

   localparam int IPART_W    = 31;
   localparam int FDIG_MAX_W = 20;
   localparam int DEC_POS_W  = 4;
   localparam int WEIGHT_W   = 34;

   localparam logic [DEC_POS_W-1:0] INT_TOP_POS = 4'd9;

   localparam logic [WEIGHT_W-1:0] POW10_TABLE [10] = '{
      34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
      34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
   };

   typedef struct packed {
      logic                  overflow;
      logic                  negative;
      logic [IPART_W-1:0]    ipart;
      logic                  has_frac;
      logic [FDIG_MAX_W-1:0] fdigits;
   } queue_entry_type;

endpackage

@@ rtl/f2da_front.sv @@
// front end: decodes the single-precision fields into integer part and scaled fraction
// depends on f2da_pkg
module f2da_front #(
   parameter int FRAC_DIGITS = 4
) (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [31:0]               req_value_bits,
   output logic                      push_valid,
   input  logic                      push_ready,
   output f2da_pkg::queue_entry_type push_entry
);
   import f2da_pkg::*;

   localparam int PROD_W = 24 + FDIG_MAX_W;
   localparam logic [FDIG_MAX_W-1:0] FRAC_SCALE = FDIG_MAX_W'(POW10_TABLE[FRAC_DIGITS]);

   logic                  sign;
   logic [7:0]            expf;
   logic [23:0]           mant;
   logic                  ovf;
   logic                  is_int;
   logic [2:0]            int_sh;
   logic [7:0]            frac_sh;
   logic [IPART_W-1:0]    int_wide;
   logic [IPART_W-1:0]    ipart;
   logic [23:0]           fbits;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W-1:0]     prod_sh;
   logic [FDIG_MAX_W-1:0] fdig;
   logic                  has_frac;

   always_comb begin
      sign     = req_value_bits[31];
      expf     = req_value_bits[30:23];
      mant     = {(expf != 8'd0), req_value_bits[22:0]};
      ovf      = (expf >= 8'd158);
      is_int   = (expf >= 8'd150);
      int_sh   = 3'(expf - 8'd150);
      frac_sh  = (expf == 8'd0) ? 8'd149 : (8'd150 - expf);
      int_wide = {7'b0, mant} << int_sh;
      if (is_int) begin
         ipart = int_wide;
         fbits = 24'd0;
      end else if (frac_sh < 8'd24) begin
         ipart = IPART_W'(mant >> frac_sh[4:0]);
         fbits = mant & ~(24'hFFFFFF << frac_sh[4:0]);
      end else begin
         ipart = '0;
         fbits = mant;
      end
      has_frac = (fbits != 24'd0);
      prod     = {{FDIG_MAX_W{1'b0}}, fbits} * {24'b0, FRAC_SCALE};
      prod_sh  = prod >> frac_sh;
      fdig     = (frac_sh < 8'(PROD_W)) ? prod_sh[FDIG_MAX_W-1:0] : '0;
   end

   assign req_ready           = push_ready;
   assign push_valid          = req_valid;
   assign push_entry.overflow = ovf;
   assign push_entry.negative = sign && ((ipart != '0) || has_frac);
   assign push_entry.ipart    = ipart;
   assign push_entry.has_frac = has_frac;
   assign push_entry.fdigits  = fdig;

endmodule

@@ rtl/f2da_queue.sv @@
// two-entry queue between front end and digit emitter
// depends on f2da_pkg
module f2da_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  f2da_pkg::queue_entry_type push_entry,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output f2da_pkg::queue_entry_type pop_entry
);
   import f2da_pkg::*;

   queue_entry_type entries_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/f2da_back.sv @@
// back end: emits sign, integer digits, dot and fraction digits, or an overflow mark
// depends on f2da_pkg and float_to_decimal_ascii_assert.svh
module f2da_back #(
   parameter int FRAC_DIGITS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  f2da_pkg::queue_entry_type pop_entry,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_text_char,
   output logic                      rsp_last,
   output logic                      rsp_overflow
);
   import f2da_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_OVF  = 3'd1;
   localparam logic [2:0] S_SIGN = 3'd2;
   localparam logic [2:0] S_INT  = 3'd3;
   localparam logic [2:0] S_DOT  = 3'd4;
   localparam logic [2:0] S_FRAC = 3'd5;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   localparam logic [DEC_POS_W-1:0] FRAC_TOP_POS = DEC_POS_W'(FRAC_DIGITS - 1);

   logic [2:0]            state_ff, state_in;
   logic [IPART_W-1:0]    val_ff, val_in;
   logic [DEC_POS_W-1:0]  pos_ff, pos_in;
   logic                  started_ff, started_in;
   logic                  has_frac_ff, has_frac_in;
   logic [FDIG_MAX_W-1:0] fdig_ff, fdig_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  ovf_ff, ovf_in;
   logic                  emit;

   logic [WEIGHT_W-1:0]   thr [10];
   logic [3:0]            digit;
   logic [WEIGHT_W-1:0]   rem_wide;
   logic [IPART_W-1:0]    rem;
   logic [7:0]            digit_char;

   // one decimal digit: compare against the multiples of the current power of ten
   always_comb begin
      digit = 4'd0;
      for (int k = 0; k < 10; k++) begin
         thr[k] = POW10_TABLE[pos_ff] * WEIGHT_W'(k);
      end
      for (int k = 1; k < 10; k++) begin
         if ({{(WEIGHT_W-IPART_W){1'b0}}, val_ff} >= thr[k]) begin
            digit = 4'(k);
         end
      end
      rem_wide   = {{(WEIGHT_W-IPART_W){1'b0}}, val_ff} - thr[digit];
      rem        = rem_wide[IPART_W-1:0];
      digit_char = CHAR_ZERO + {4'b0, digit};
   end

   assign emit = !valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      val_in      = val_ff;
      pos_in      = pos_ff;
      started_in  = started_ff;
      has_frac_in = has_frac_ff;
      fdig_in     = fdig_ff;
      valid_in    = valid_ff && !rsp_ready;
      char_in     = char_ff;
      last_in     = last_ff;
      ovf_in      = ovf_ff;
      pop_ready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               pop_ready   = 1'b1;
               val_in      = pop_entry.ipart;
               has_frac_in = pop_entry.has_frac;
               fdig_in     = pop_entry.fdigits;
               pos_in      = INT_TOP_POS;
               started_in  = 1'b0;
               if (pop_entry.overflow) begin
                  state_in = S_OVF;
               end else if (pop_entry.negative) begin
                  state_in = S_SIGN;
               end else begin
                  state_in = S_INT;
               end
            end
         end
         S_OVF: begin
            if (emit) begin
               valid_in = 1'b1;
               char_in  = 8'd0;
               last_in  = 1'b1;
               ovf_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SIGN: begin
            if (emit) begin
               valid_in = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               ovf_in   = 1'b0;
               state_in = S_INT;
            end
         end
         S_INT: begin
            if (emit) begin
               // leading zeros are skipped without a transaction
               if ((digit != 4'd0) || started_ff || (pos_ff == '0)) begin
                  valid_in   = 1'b1;
                  char_in    = digit_char;
                  last_in    = 1'b0;
                  ovf_in     = 1'b0;
                  started_in = 1'b1;
               end
               val_in = rem;
               if (pos_ff == '0) begin
                  state_in = S_DOT;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         S_DOT: begin
            if (emit) begin
               valid_in = 1'b1;
               char_in  = CHAR_DOT;
               last_in  = !has_frac_ff;
               ovf_in   = 1'b0;
               val_in   = {{(IPART_W-FDIG_MAX_W){1'b0}}, fdig_ff};
               pos_in   = FRAC_TOP_POS;
               state_in = has_frac_ff ? S_FRAC : S_IDLE;
            end
         end
         S_FRAC: begin
            if (emit) begin
               valid_in = 1'b1;
               char_in  = digit_char;
               last_in  = (pos_ff == '0);
               ovf_in   = 1'b0;
               val_in   = rem;
               if (pos_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      started_ff  <= started_in;
      has_frac_ff <= has_frac_in;
      fdig_ff     <= fdig_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
      ovf_ff      <= ovf_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_overflow  = ovf_ff;

   `include "float_to_decimal_ascii_assert.svh"

   `F2DA_ASSERT_NOW(ovf_is_single, clock, reset, valid_ff && ovf_ff, last_ff && (char_ff == 8'd0))
   `F2DA_ASSERT_NOW(pop_only_idle, clock, reset, pop_ready, (state_ff == S_IDLE) && pop_valid)
   `F2DA_ASSERT_NOW(frac_pos_bound, clock, reset, state_ff == S_FRAC, pos_ff <= FRAC_TOP_POS)
   `F2DA_ASSERT_NEXT(int_to_dot, clock, reset, (state_ff == S_INT) && (pos_ff == '0) && emit,
                     state_ff == S_DOT)

endmodule

@@ rtl/float_to_decimal_ascii.sv @@
// top level of the single-precision to decimal text formatter
// depends on f2da_pkg, f2da_front, f2da_queue and f2da_back
//
//   channel   direction   payload                               handshake
//   req       in          value_bits[31:0]                      req_valid / req_ready
//   rsp       out         text_char[7:0], last, overflow        rsp_valid / rsp_ready
//
// a number takes a load step, a sign step if it is negative, 10 integer digit steps
// (leading zeros give no transaction), a dot step and, when there is a fraction,
// FRAC_DIGITS fraction steps; the back end makes one digit a cycle unless rsp stalls
// an overflow gives one transaction; the front end takes a number every cycle while the
// two-entry queue has room, so req stalls only when the queue is full
// reset is synchronous and empties queue and output register
module float_to_decimal_ascii #(
   parameter int FRAC_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_last,
   output logic        rsp_overflow
);
   import f2da_pkg::*;

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_entry;

   f2da_front #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value_bits (req_value_bits),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   f2da_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   f2da_back #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_entry     (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last      (rsp_last),
      .rsp_overflow  (rsp_overflow)
   );

endmodule
